@@ src/bxrs_pkg.sv @@
// Shared types, constants and controller/datapath command types for the random source.
package bxrs_pkg;

  typedef logic [63:0] word_t;

  localparam word_t GoldenGamma = 64'h9e3779b97f4a7c15;
  localparam word_t MixMulA     = 64'hbf58476d1ce4e5b9;
  localparam word_t MixMulB     = 64'h94d049bb133111eb;

  localparam int unsigned ShiftMix0 = 30;
  localparam int unsigned ShiftMix1 = 27;
  localparam int unsigned ShiftMix2 = 31;
  localparam int unsigned ShiftXs   = 17;
  localparam int unsigned RotState  = 45;
  localparam int unsigned RotOut    = 7;

  localparam int unsigned NumWords = 4;
  typedef logic [$clog2(NumWords)-1:0] widx_t;
  localparam widx_t LastWord = widx_t'(NumWords - 1);

  localparam int unsigned ApbAddrW = 1;
  typedef logic [ApbAddrW-1:0] apb_addr_t;
  typedef enum logic [ApbAddrW-1:0] {
    REG_SEED = 1'b0
  } reg_addr_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ADD,
    ST_MLO,
    ST_MX1,
    ST_MX2,
    ST_MIX,
    ST_IDLE,
    ST_PREP,
    ST_DRAW,
    ST_DONE
  } state_e;

  typedef enum logic {
    SEL_A,
    SEL_B
  } msel_e;

  typedef struct packed {
    logic  acc_load;
    logic  seed_add;
    logic  mul_lo;
    logic  mul_x1;
    logic  mul_x2;
    msel_e mul_sel;
    logic  mix_z;
    logic  word_wr;
    widx_t widx;
    logic  req_load;
    logic  mask_load;
    logic  step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

endpackage

@@ src/bxrs_if.sv @@
// Valid/ready channel interfaces for bound requests and drawn values.
interface bxrs_req_if;
  import bxrs_pkg::*;
  logic  valid;
  logic  ready;
  word_t lower;
  word_t upper;
  modport source (output valid, output lower, output upper, input ready);
  modport sink (input valid, input lower, input upper, output ready);
endinterface

interface bxrs_rsp_if;
  import bxrs_pkg::*;
  logic  valid;
  logic  ready;
  word_t value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ src/bxrs_ctrl.sv @@
// Controller state machine: seeding sequence and per-transaction draw loop.
module bxrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_wr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bxrs_pkg::status_t st_i,
  output bxrs_pkg::cmd_t    cmd_o
);
  import bxrs_pkg::*;

  state_e state_q, state_d;
  msel_e  sel_q, sel_d;
  widx_t  widx_q, widx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      sel_q   <= SEL_A;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      widx_q  <= widx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    widx_d  = widx_q;
    if (seed_wr_i) begin
      state_d = ST_LOAD;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          state_d = ST_ADD;
          sel_d   = SEL_A;
          widx_d  = '0;
        end
        ST_ADD: state_d = ST_MLO;
        ST_MLO: state_d = ST_MX1;
        ST_MX1: state_d = ST_MX2;
        ST_MX2: state_d = ST_MIX;
        ST_MIX: begin
          if (sel_q == SEL_A) begin
            sel_d   = SEL_B;
            state_d = ST_MLO;
          end else if (widx_q == LastWord) begin
            state_d = ST_IDLE;
          end else begin
            widx_d  = widx_q + widx_t'(1);
            sel_d   = SEL_A;
            state_d = ST_ADD;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) state_d = ST_PREP;
        end
        ST_PREP: state_d = ST_DRAW;
        ST_DRAW: begin
          if (st_i.hit) state_d = ST_DONE;
        end
        ST_DONE: begin
          if (st_i.out_free) state_d = ST_IDLE;
        end
        default: state_d = ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = sel_q;
    cmd_o.widx    = widx_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_LOAD: cmd_o.acc_load = 1'b1;
      ST_ADD:  cmd_o.seed_add = 1'b1;
      ST_MLO:  cmd_o.mul_lo   = 1'b1;
      ST_MX1:  cmd_o.mul_x1   = 1'b1;
      ST_MX2:  cmd_o.mul_x2   = 1'b1;
      ST_MIX: begin
        if (sel_q == SEL_A) begin
          cmd_o.mix_z = 1'b1;
        end else begin
          cmd_o.word_wr = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.req_load = in_valid_i;
      end
      ST_PREP: cmd_o.mask_load = 1'b1;
      ST_DRAW: cmd_o.step      = 1'b1;
      ST_DONE: cmd_o.out_load  = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_seed_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_wr_i |=> state_q == ST_LOAD)
    else $error("seed write did not restart seeding");

  a_seed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX && sel_q == SEL_B && widx_q == LastWord && !seed_wr_i)
      |=> state_q == ST_IDLE)
    else $error("seeding did not end after the last word");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW && st_i.hit && !seed_wr_i) |=> state_q == ST_DONE)
    else $error("accepted draw did not finish the transaction");

endmodule

@@ src/bxrs_dp.sv @@
// Datapath: splitmix64 expansion, xoshiro256** state, bounding and result register.
module bxrs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bxrs_pkg::cmd_t    cmd_i,
  output bxrs_pkg::status_t st_o,
  input  bxrs_pkg::word_t   seed_i,
  input  bxrs_pkg::word_t   lower_i,
  input  bxrs_pkg::word_t   upper_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bxrs_pkg::word_t   value_o
);
  import bxrs_pkg::*;

  function automatic word_t rotl(input word_t v, input int unsigned amt);
    return (v << amt) | (v >> (64 - amt));
  endfunction

  function automatic word_t smear(input word_t s);
    word_t m;
    m = s;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

  word_t acc_q, z_q, prod_q, pre_q, pre_d;
  word_t gen_q [NumWords];
  word_t gen_d [NumWords];
  word_t lower_q, span_q, mask_q, r_q, value_q;
  logic  out_valid_q;

  word_t       acc_inc, k_sel, mix_word, draw_val, draw_r, t_xs, g2x, g3x;
  logic [31:0] op_a, op_b;
  logic [63:0] mp;

  assign acc_inc  = acc_q + GoldenGamma;
  assign k_sel    = (cmd_i.mul_sel == SEL_A) ? MixMulA : MixMulB;
  assign op_a     = cmd_i.mul_x2 ? z_q[63:32] : z_q[31:0];
  assign op_b     = cmd_i.mul_x1 ? k_sel[63:32] : k_sel[31:0];
  assign mp       = {32'b0, op_a} * {32'b0, op_b};
  assign mix_word = prod_q ^ (prod_q >> ShiftMix2);

  // pre_q holds rotl(g1 * 5, 7); times 9 is a shift-add
  assign draw_val = pre_q + {pre_q[60:0], 3'b000};
  assign draw_r   = draw_val & mask_q;
  assign st_o.hit = draw_r <= span_q;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  assign t_xs = gen_q[1] << ShiftXs;
  assign g2x  = gen_q[2] ^ gen_q[0];
  assign g3x  = gen_q[3] ^ gen_q[1];

  always_comb begin
    gen_d = gen_q;
    if (cmd_i.step) begin
      gen_d[0] = gen_q[0] ^ g3x;
      gen_d[1] = gen_q[1] ^ g2x;
      gen_d[2] = g2x ^ t_xs;
      gen_d[3] = rotl(g3x, RotState);
    end else if (cmd_i.word_wr) begin
      gen_d[cmd_i.widx] = mix_word;
    end
  end

  assign pre_d = rotl(gen_d[1] + {gen_d[1][61:0], 2'b00}, RotOut);

  always_ff @(posedge clk_i) begin
    gen_q <= gen_d;
    pre_q <= pre_d;
    if (cmd_i.acc_load) acc_q <= seed_i;
    if (cmd_i.seed_add) begin
      acc_q <= acc_inc;
      z_q   <= acc_inc ^ (acc_inc >> ShiftMix0);
    end
    if (cmd_i.mix_z) z_q <= prod_q ^ (prod_q >> ShiftMix1);
    if (cmd_i.mul_lo) prod_q <= mp;
    if (cmd_i.mul_x1 || cmd_i.mul_x2) prod_q[63:32] <= prod_q[63:32] + mp[31:0];
    if (cmd_i.req_load) begin
      lower_q <= lower_i;
      span_q  <= upper_i - lower_i;
    end
    if (cmd_i.mask_load) mask_q <= smear(span_q);
    if (cmd_i.step) r_q <= draw_r;
    if (cmd_i.out_load) value_q <= lower_q + r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  a_draw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && st_o.hit) |=> r_q <= span_q)
    else $error("accepted draw exceeds span");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result load did not raise valid");

endmodule

@@ src/bounded_xoshiro_random_source_unit.sv @@
// Bounded xoshiro256** random source, top level with APB seed register.
// Each transaction on req_i returns one value on rsp_o, uniform over lower..upper (wrapping
// modulo 2^64). A rejected draw is retried (fewer than two draws on average), with a single
// xoshiro256** step per cycle in the draw loop.
// After reset and after every write of the seed register, req_i.ready stays low
// while splitmix64 expands the seed into the four state words through one shared
// 32x32 multiplier (three partial products per 64-bit multiply). A finished value waits in
// the output register while the next transaction is accepted.
module bounded_xoshiro_random_source_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  bxrs_pkg::apb_addr_t paddr_i,
  input  bxrs_pkg::word_t     pwdata_i,
  output bxrs_pkg::word_t     prdata_o,
  output logic                pready_o,
  bxrs_req_if.sink            req_i,
  bxrs_rsp_if.source          rsp_o
);
  import bxrs_pkg::*;

  word_t   seed_q;
  logic    seed_wr;
  cmd_t    cmd;
  status_t st;

  assign pready_o = 1'b1;
  assign seed_wr  = psel_i && penable_i && pwrite_i && (reg_addr_e'(paddr_i) == REG_SEED);
  assign prdata_o = (reg_addr_e'(paddr_i) == REG_SEED) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_wr) begin
      seed_q <= pwdata_i;
    end
  end

  bxrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_wr_i  (seed_wr),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bxrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .seed_i      (seed_q),
    .lower_i     (req_i.lower),
    .upper_i     (req_i.upper),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .value_o     (rsp_o.value)
  );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the bounded xoshiro256** random source: seeds, bounds, handshakes.
`timescale 1ns / 100ps

module tb_top;
  import bxrs_pkg::*;

  typedef struct packed {
    word_t lower;
    word_t upper;
  } bounds_t;

  localparam word_t SplitGamma = 64'h9e3779b97f4a7c15;
  localparam word_t SplitMulA  = 64'hbf58476d1ce4e5b9;
  localparam word_t SplitMulB  = 64'h94d049bb133111eb;
  localparam word_t MaxWord    = '1;
  localparam word_t TopBit     = 64'h8000000000000000;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned LongHold   = 250;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      psel;
  logic      penable;
  logic      pwrite;
  apb_addr_t paddr;
  word_t     pwdata;
  word_t     prdata;
  logic      pready;

  bxrs_req_if req_if ();
  bxrs_rsp_if rsp_if ();

  bounded_xoshiro_random_source_unit u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .req_i     (req_if.sink),
    .rsp_o     (rsp_if.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // xoshiro256** state tracked by the bench
  word_t       xs_words [4];
  bounds_t     pending_reqs [$];
  word_t       expected_values [$];
  bounds_t     req_next;
  logic        req_taken = 1'b0;
  logic        no_idle = 1'b0;
  logic        rsp_hold_req = 1'b0;
  int unsigned req_gap = 0;
  int unsigned rsp_gap = 0;
  int unsigned rsp_hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned value_errors = 0;
  int unsigned cfg_errors = 0;

  function automatic word_t rotl64(word_t v, int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

  function automatic void reseed_words(word_t s);
    word_t acc;
    word_t z;
    acc = s;
    for (int i = 0; i < 4; i++) begin
      acc = acc + SplitGamma;
      z = acc;
      z = (z ^ (z >> 30)) * SplitMulA;
      z = (z ^ (z >> 27)) * SplitMulB;
      xs_words[i] = z ^ (z >> 31);
    end
  endfunction

  function automatic word_t xs_step();
    word_t res;
    word_t t;
    res = rotl64(xs_words[1] * 64'd5, 7) * 64'd9;
    t = xs_words[1] << 17;
    xs_words[2] = xs_words[2] ^ xs_words[0];
    xs_words[3] = xs_words[3] ^ xs_words[1];
    xs_words[1] = xs_words[1] ^ xs_words[2];
    xs_words[0] = xs_words[0] ^ xs_words[3];
    xs_words[2] = xs_words[2] ^ t;
    xs_words[3] = rotl64(xs_words[3], 45);
    return res;
  endfunction

  function automatic word_t bounded_value(word_t lo, word_t hi);
    word_t span;
    word_t mask;
    word_t r;
    span = hi - lo;
    if ((span & (span + 64'd1)) == 64'd0) return lo + (xs_step() & span);
    mask = span;
    mask = mask | (mask >> 1);
    mask = mask | (mask >> 2);
    mask = mask | (mask >> 4);
    mask = mask | (mask >> 8);
    mask = mask | (mask >> 16);
    mask = mask | (mask >> 32);
    r = xs_step() & mask;
    while (r > span) r = xs_step() & mask;
    return lo + r;
  endfunction

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(word_t lo, word_t hi);
    pending_reqs.insert(pending_reqs.size(), '{lower: lo, upper: hi});
  endtask

  task automatic push_random(int unsigned n);
    word_t lo;
    word_t hi;
    int unsigned k;
    repeat (n) begin
      lo = rand64();
      k = $urandom_range(0, 64);
      case ($urandom_range(0, 9)) inside
        [0:1]: hi = rand64();
        [2:4]: hi = lo + (rand64() & ((64'd1 << k) - 64'd1));
        5: hi = lo + (64'd1 << (k % 64));
        6: hi = lo + ((64'd1 << k) - 64'd1);
        7: hi = lo;
        default: hi = lo + word_t'($urandom_range(0, 20));
      endcase
      push_item(lo, hi);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_values.size() != 0);
  endtask

  // write the seed, then read it back
  task automatic write_seed(word_t s);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SEED;
    pwdata  <= s;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    reseed_words(s);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== s) begin
      $display("%0t: seed readback mismatch, expected %h, got %h", $time, s, prdata);
      cfg_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (req_if.valid && !req_taken) begin
      end else if (req_gap != 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req_next = pending_reqs.pop_front();
        req_if.valid <= 1'b1;
        req_if.lower <= req_next.lower;
        req_if.upper <= req_next.upper;
        req_gap = idle_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rsp_hold_req) begin
      rsp_hold_req = 1'b0;
      rsp_hold_left = LongHold;
    end
    if (rsp_hold_left != 0) begin
      rsp_hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (rsp_gap != 0) begin
      rsp_gap--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rsp_gap = idle_gap();
    end
  end

  always @(posedge clk) begin
    word_t want;
    req_taken <= req_if.valid && req_if.ready;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %h", $time, rsp_if.value);
          value_errors++;
        end else begin
          want = expected_values.pop_front();
          if (rsp_if.value !== want) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, want, rsp_if.value);
            value_errors++;
          end
        end
      end
      if (req_if.valid && req_if.ready)
        expected_values.insert(expected_values.size(),
                               bounded_value(req_if.lower, req_if.upper));
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = REG_SEED;
    pwdata       = '0;
    req_if.valid = 1'b0;
    req_if.lower = '0;
    req_if.upper = '0;
    rsp_if.ready = 1'b0;
    reseed_words(64'd0);
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // extremes, wrapped bounds, exact masks and worst-case rejection
    push_item(64'd0, 64'd0);
    push_item(MaxWord, MaxWord);
    push_item(64'd0, MaxWord);
    push_item(64'd1, 64'd0);
    push_item(TopBit, TopBit - 64'd1);
    push_item(MaxWord, 64'd0);
    push_item(MaxWord - 64'd2, 64'd2);
    push_item(64'd10, 64'd5);
    push_item(64'd0, 64'd1);
    push_item(64'd0, 64'd2);
    push_item(64'd0, 64'd6);
    push_item(64'd0, 64'd7);
    push_item(64'd5, 64'd5);
    push_item(64'd0, TopBit);
    push_item(64'd0, TopBit - 64'd1);
    push_item(64'd100, 64'd100 + 64'h1_0000_0000);
    push_item(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    push_item(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    push_item(MaxWord - 64'd1, MaxWord);
    push_item(64'd3, 64'd3 + 64'h2_0000_0000);
    push_random(280);
    wait_drained();

    write_seed(MaxWord);
    push_random(300);
    @(posedge clk);
    rsp_hold_req = 1'b1;
    wait_drained();

    no_idle = 1'b1;
    write_seed(64'd0);
    push_random(300);
    wait_drained();
    no_idle = 1'b0;

    write_seed(rand64());
    push_random(400);
    @(posedge clk);
    rsp_hold_req = 1'b1;
    wait_drained();

    write_seed(64'd1);
    push_random(300);
    wait_drained();

    write_seed(TopBit);
    push_random(350);
    wait_drained();

    repeat (20) @(posedge clk);
    if (value_errors == 0 && cfg_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
